@@ design/lru_page_replacement_assert.svh @@
// Assertion macros shared by the LRU page replacement modules.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef LRU_PAGE_REPLACEMENT_ASSERT_SVH
`define LRU_PAGE_REPLACEMENT_ASSERT_SVH

// Same-cycle implication.
`define LRUPR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define LRUPR_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/lrupr_pkg.sv @@
`timescale 1ns / 1ps
package lrupr_pkg;

    localparam int FRAMES_DEF     = 8;
    localparam int PAGE_BITS_DEF  = 16;
    localparam int COUNT_BITS_DEF = 16;

    localparam int CFG_BITS      = 4;
    localparam int SLOT_OUT_BITS = 3;

    localparam logic [CFG_BITS-1:0] NUM_FRAMES_RST = 4'd3;

    // Control from the sequencer to the statistics counters.
    typedef struct packed {
        logic clear;
        logic commit;
        logic hit;
    } stats_ctl_t;

endpackage

@@ design/lrupr_in_if.sv @@
`timescale 1ns / 1ps
interface lrupr_in_if
    import lrupr_pkg::*;
#(
    parameter int PAGE_BITS = PAGE_BITS_DEF
);
    logic                 valid;
    logic                 ready;
    logic [PAGE_BITS-1:0] page_number;
    logic                 start_sequence;

    modport source (output valid, output page_number, output start_sequence, input ready);
    modport sink (input valid, input page_number, input start_sequence, output ready);
endinterface

@@ design/lrupr_out_if.sv @@
`timescale 1ns / 1ps
interface lrupr_out_if
    import lrupr_pkg::*;
#(
    parameter int PAGE_BITS  = PAGE_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
);
    logic                     valid;
    logic                     ready;
    logic                     hit;
    logic [SLOT_OUT_BITS-1:0] frame_slot;
    logic                     evicted_valid;
    logic [PAGE_BITS-1:0]     evicted_page;
    logic [COUNT_BITS-1:0]    hit_total;
    logic [COUNT_BITS-1:0]    fault_total;
    logic [COUNT_BITS-1:0]    requests_seen;

    modport source (
        output valid, output hit, output frame_slot, output evicted_valid,
        output evicted_page, output hit_total, output fault_total, output requests_seen,
        input ready
    );
    modport sink (
        input valid, input hit, input frame_slot, input evicted_valid,
        input evicted_page, input hit_total, input fault_total, input requests_seen,
        output ready
    );
endinterface

@@ design/lrupr_stats.sv @@
`timescale 1ns / 1ps
`include "lru_page_replacement_assert.svh"
module lrupr_stats
    import lrupr_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  stats_ctl_t            ctl,
    output logic [COUNT_BITS-1:0] hit_next,
    output logic [COUNT_BITS-1:0] fault_next,
    output logic [COUNT_BITS-1:0] req_next
);

    logic [COUNT_BITS-1:0] hit_cnt_reg;
    logic [COUNT_BITS-1:0] fault_cnt_reg;
    logic [COUNT_BITS-1:0] req_cnt_reg;

    // Each count holds once it reaches all ones.
    always_comb
    begin
        req_next   = (req_cnt_reg == '1) ? req_cnt_reg : req_cnt_reg + 1'b1;
        hit_next   = hit_cnt_reg;
        fault_next = fault_cnt_reg;
        if (ctl.hit)
        begin
            hit_next = (hit_cnt_reg == '1) ? hit_cnt_reg : hit_cnt_reg + 1'b1;
        end
        else
        begin
            fault_next = (fault_cnt_reg == '1) ? fault_cnt_reg : fault_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_cnt_reg   <= '0;
            fault_cnt_reg <= '0;
            req_cnt_reg   <= '0;
        end
        else if (ctl.clear)
        begin
            hit_cnt_reg   <= '0;
            fault_cnt_reg <= '0;
            req_cnt_reg   <= '0;
        end
        else if (ctl.commit)
        begin
            hit_cnt_reg   <= hit_next;
            fault_cnt_reg <= fault_next;
            req_cnt_reg   <= req_next;
        end
    end

    `LRUPR_ASSERT_IMP(a_hits_le_requests, 1'b1, hit_cnt_reg <= req_cnt_reg, "hit count above request count")
    `LRUPR_ASSERT_IMP(a_faults_le_requests, 1'b1, fault_cnt_reg <= req_cnt_reg, "fault count above request count")
    `LRUPR_ASSERT_NXT(a_clear_zeroes, ctl.clear, req_cnt_reg == '0, "request count not cleared")

endmodule

@@ design/lru_page_replacement.sv @@
`timescale 1ns / 1ps
// Channel  Direction  Payload
// req      in         page_number, start_sequence
// rsp      out        hit, frame_slot, evicted_valid, evicted_page, hit_total,
//                     fault_total, requests_seen
// cfg      in         num_frames (write only)
//
// Each item is accepted in ST_IDLE; ST_SCAN then passes the first eff frames,
// where eff is num_frames clamped to 1..FRAMES, one by one through the shared
// compare unit, and ST_UPDATE updates the ranks and frame contents.
// Reset clears the valid bits, ranks and counts at once; num_frames resets to 3.
// A waiting result does not block the next item; only the update of that item
// stalls until the result register is free.
`include "lru_page_replacement_assert.svh"
module lru_page_replacement
    import lrupr_pkg::*;
#(
    parameter int FRAMES     = FRAMES_DEF,
    parameter int PAGE_BITS  = PAGE_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [CFG_BITS-1:0] cfg_wr_data,
    lrupr_in_if.sink            req,
    lrupr_out_if.source         rsp
);

    localparam int IDX_BITS = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int EFF_BITS = $clog2(FRAMES + 1);
    localparam logic [IDX_BITS-1:0] RANK_MAX = IDX_BITS'(FRAMES - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } state_t;

    state_t                state_reg;
    state_t                state_next;
    logic [CFG_BITS-1:0]   num_frames_reg;
    logic [EFF_BITS-1:0]   eff;
    logic [IDX_BITS-1:0]   idx_reg;
    logic [FRAMES-1:0]     valid_reg;
    logic [IDX_BITS-1:0]   rank_reg [FRAMES];
    logic [IDX_BITS-1:0]   rank_aged [FRAMES];
    logic [PAGE_BITS-1:0]  page_mem_reg [FRAMES];

    logic                  found_reg;
    logic                  empty_reg;
    logic [IDX_BITS-1:0]   hit_slot_reg;
    logic [IDX_BITS-1:0]   hit_rank_reg;
    logic [IDX_BITS-1:0]   empty_slot_reg;
    logic [IDX_BITS-1:0]   best_slot_reg;
    logic [IDX_BITS-1:0]   best_rank_reg;
    logic [PAGE_BITS-1:0]  best_page_reg;
    logic [PAGE_BITS-1:0]  page_reg;

    logic                  out_valid_reg;
    logic                  out_hit_reg;
    logic [IDX_BITS-1:0]   out_slot_reg;
    logic                  out_evict_reg;
    logic [PAGE_BITS-1:0]  out_evicted_page_reg;
    logic [COUNT_BITS-1:0] out_hits_reg;
    logic [COUNT_BITS-1:0] out_faults_reg;
    logic [COUNT_BITS-1:0] out_reqs_reg;

    logic                  accept;
    logic                  commit;
    logic                  scan_last;
    logic                  cur_valid;
    logic                  cur_match;
    logic [IDX_BITS-1:0]   cur_rank;
    logic [IDX_BITS-1:0]   upd_slot;
    logic [IDX_BITS-1:0]   upd_limit;
    logic                  upd_age_all;
    logic                  upd_evict;

    stats_ctl_t            stats_ctl;
    logic [COUNT_BITS-1:0] hit_next;
    logic [COUNT_BITS-1:0] fault_next;
    logic [COUNT_BITS-1:0] req_next;

    // Frames in use, clamped to 1..FRAMES.
    always_comb
    begin
        if (num_frames_reg == '0)
        begin
            eff = EFF_BITS'(1);
        end
        else if (32'(num_frames_reg) > FRAMES)
        begin
            eff = EFF_BITS'(FRAMES);
        end
        else
        begin
            eff = EFF_BITS'(num_frames_reg);
        end
    end

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && (state_reg == ST_IDLE);
    assign commit    = (state_reg == ST_UPDATE) && (!out_valid_reg || rsp.ready);
    assign scan_last = ((EFF_BITS'(idx_reg) + EFF_BITS'(1)) == eff);

    // The shared compare unit looks at one frame per scan cycle.
    assign cur_valid = valid_reg[idx_reg];
    assign cur_match = (page_mem_reg[idx_reg] == page_reg);
    assign cur_rank  = rank_reg[idx_reg];

    always_comb
    begin
        upd_age_all = !found_reg && empty_reg;
        upd_evict   = !found_reg && !empty_reg;
        if (found_reg)
        begin
            upd_slot  = hit_slot_reg;
            upd_limit = hit_rank_reg;
        end
        else if (empty_reg)
        begin
            upd_slot  = empty_slot_reg;
            upd_limit = hit_rank_reg;
        end
        else
        begin
            upd_slot  = best_slot_reg;
            upd_limit = best_rank_reg;
        end
    end

    // Frames younger than the touched one age by one; the touched frame becomes
    // the most recent. Filling an empty frame ages every valid frame in range.
    always_comb
    begin
        for (int i = 0; i < FRAMES; i++)
        begin
            rank_aged[i] = rank_reg[i];
            if (IDX_BITS'(i) == upd_slot)
            begin
                rank_aged[i] = '0;
            end
            else if (i < int'(eff) && valid_reg[i]
                     && (upd_age_all || rank_reg[i] < upd_limit)
                     && rank_reg[i] != RANK_MAX)
            begin
                rank_aged[i] = rank_reg[i] + 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            num_frames_reg <= NUM_FRAMES_RST;
            idx_reg        <= '0;
            found_reg      <= 1'b0;
            empty_reg      <= 1'b0;
            valid_reg      <= '0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < FRAMES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                num_frames_reg <= cfg_wr_data;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        idx_reg   <= '0;
                        found_reg <= 1'b0;
                        empty_reg <= 1'b0;
                        if (req.start_sequence)
                        begin
                            valid_reg <= '0;
                            for (int i = 0; i < FRAMES; i++)
                            begin
                                rank_reg[i] <= '0;
                            end
                        end
                    end
                end
                ST_SCAN:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (!found_reg && cur_valid && cur_match)
                    begin
                        found_reg <= 1'b1;
                    end
                    if (!empty_reg && !cur_valid)
                    begin
                        empty_reg <= 1'b1;
                    end
                end
                ST_UPDATE:
                begin
                    if (commit)
                    begin
                        valid_reg[upd_slot] <= 1'b1;
                        for (int i = 0; i < FRAMES; i++)
                        begin
                            rank_reg[i] <= rank_aged[i];
                        end
                    end
                end
                default:
                begin
                    idx_reg <= '0;
                end
            endcase
            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers; their values only matter under the control state above.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            page_reg <= req.page_number;
        end
        if (state_reg == ST_SCAN)
        begin
            if (!found_reg && cur_valid && cur_match)
            begin
                hit_slot_reg <= idx_reg;
                hit_rank_reg <= cur_rank;
            end
            if (!empty_reg && !cur_valid)
            begin
                empty_slot_reg <= idx_reg;
            end
            // Strictly greater keeps the lowest frame on a tie.
            if (idx_reg == '0 || cur_rank > best_rank_reg)
            begin
                best_slot_reg <= idx_reg;
                best_rank_reg <= cur_rank;
                best_page_reg <= page_mem_reg[idx_reg];
            end
        end
        if (commit)
        begin
            if (!found_reg)
            begin
                page_mem_reg[upd_slot] <= page_reg;
            end
            out_hit_reg          <= found_reg;
            out_slot_reg         <= upd_slot;
            out_evict_reg        <= upd_evict;
            out_evicted_page_reg <= upd_evict ? best_page_reg : '0;
            out_hits_reg         <= hit_next;
            out_faults_reg       <= fault_next;
            out_reqs_reg         <= req_next;
        end
    end

    assign stats_ctl.clear  = accept && req.start_sequence;
    assign stats_ctl.commit = commit;
    assign stats_ctl.hit    = found_reg;

    lrupr_stats #(
        .COUNT_BITS (COUNT_BITS)
    ) u_stats (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (stats_ctl),
        .hit_next   (hit_next),
        .fault_next (fault_next),
        .req_next   (req_next)
    );

    assign rsp.valid         = out_valid_reg;
    assign rsp.hit           = out_hit_reg;
    assign rsp.frame_slot    = SLOT_OUT_BITS'(out_slot_reg);
    assign rsp.evicted_valid = out_evict_reg;
    assign rsp.evicted_page  = out_evicted_page_reg;
    assign rsp.hit_total     = out_hits_reg;
    assign rsp.fault_total   = out_faults_reg;
    assign rsp.requests_seen = out_reqs_reg;

    `LRUPR_ASSERT_IMP(a_hit_no_evict, out_valid_reg && out_hit_reg, !out_evict_reg, "hit reported an eviction")
    `LRUPR_ASSERT_IMP(a_slot_in_range, out_valid_reg, EFF_BITS'(out_slot_reg) < eff, "result frame outside frames in use")
    `LRUPR_ASSERT_IMP(a_scan_in_range, state_reg == ST_SCAN, EFF_BITS'(idx_reg) < eff, "scan index outside frames in use")
    `LRUPR_ASSERT_IMP(a_result_from_update, $rose(out_valid_reg), $past(state_reg == ST_UPDATE), "result appeared without an update")

endmodule

@@ tb/lrupr_lookup_checker.sv @@
`timescale 1ns / 1ps
module lrupr_lookup_checker
    import lrupr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [CFG_BITS-1:0] cfg_wr_data,
    lrupr_in_if                 req,
    lrupr_out_if                rsp,
    output int                  mismatches,
    output int                  pending_results
);
    localparam int FRAMES    = FRAMES_DEF;
    localparam int RANK_MAX  = FRAMES_DEF - 1;
    localparam int RANK_BITS = (FRAMES_DEF > 1) ? $clog2(FRAMES_DEF) : 1;

    typedef struct packed {
        logic                      hit;
        logic [SLOT_OUT_BITS-1:0]  slot;
        logic                      evicted;
        logic [PAGE_BITS_DEF-1:0]  victim;
        logic [COUNT_BITS_DEF-1:0] hits;
        logic [COUNT_BITS_DEF-1:0] faults;
        logic [COUNT_BITS_DEF-1:0] requests;
    } lookup_t;

    logic [PAGE_BITS_DEF-1:0]  held_page [FRAMES];
    logic                      held_valid [FRAMES];
    logic [RANK_BITS-1:0]      age [FRAMES];
    logic [COUNT_BITS_DEF-1:0] hit_cnt;
    logic [COUNT_BITS_DEF-1:0] fault_cnt;
    logic [COUNT_BITS_DEF-1:0] req_cnt;
    logic [CFG_BITS-1:0]       frames_cfg;
    lookup_t                   due_lookups [$];
    lookup_t                   got_lookup;
    lookup_t                   want_lookup;
    lookup_t                   new_lookup;

    task automatic clear_sequence();
        int i;
        for (i = 0; i < FRAMES; i++)
        begin
            held_page[i]  = '0;
            held_valid[i] = 1'b0;
            age[i]        = '0;
        end
        hit_cnt   = '0;
        fault_cnt = '0;
        req_cnt   = '0;
    endtask

    // Works out the answer to one page reference and updates the frame table.
    task automatic lru_lookup(input logic [PAGE_BITS_DEF-1:0] pg, input logic st,
                              output lookup_t res);
        int  eff;
        int  slot;
        int  limit;
        int  i;
        bit  found;
        bit  vacant;
        res = '0;
        if (st)
            clear_sequence();
        eff = int'(frames_cfg);
        if (eff == 0)
            eff = 1;
        if (eff > FRAMES)
            eff = FRAMES;
        if (req_cnt != '1)
            req_cnt++;

        found = 1'b0;
        slot  = 0;
        for (i = 0; i < eff; i++)
        begin
            if (!found && held_valid[i] && held_page[i] == pg)
            begin
                found = 1'b1;
                slot  = i;
            end
        end

        if (found)
        begin
            if (hit_cnt != '1)
                hit_cnt++;
            limit = int'(age[slot]);
        end
        else
        begin
            if (fault_cnt != '1)
                fault_cnt++;
            vacant = 1'b0;
            for (i = 0; i < eff; i++)
            begin
                if (!vacant && !held_valid[i])
                begin
                    vacant = 1'b1;
                    slot   = i;
                end
            end
            if (vacant)
                limit = FRAMES;
            else
            begin
                // Oldest frame wins; a strict compare keeps the lowest index on ties.
                slot = 0;
                for (i = 1; i < eff; i++)
                begin
                    if (age[i] > age[slot])
                        slot = i;
                end
                res.evicted = 1'b1;
                res.victim  = held_page[slot];
                limit       = int'(age[slot]);
            end
        end

        for (i = 0; i < eff; i++)
        begin
            if (i != slot && held_valid[i] && age[i] < limit && age[i] != RANK_MAX)
                age[i] = age[i] + 1'b1;
        end
        age[slot] = '0;
        if (!found)
        begin
            held_page[slot]  = pg;
            held_valid[slot] = 1'b1;
        end

        res.hit      = found;
        res.slot     = slot[SLOT_OUT_BITS-1:0];
        res.hits     = hit_cnt;
        res.faults   = fault_cnt;
        res.requests = req_cnt;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_sequence();
            frames_cfg = NUM_FRAMES_RST;
            due_lookups.delete();
            pending_results = 0;
        end
        else
        begin
            if (cfg_wr_en)
                frames_cfg = cfg_wr_data;

            // Results are retired before new items are queued, so a result can
            // never be matched against an item accepted at the same edge.
            if (rsp.valid && rsp.ready)
            begin
                got_lookup = {rsp.hit, rsp.frame_slot, rsp.evicted_valid, rsp.evicted_page,
                              rsp.hit_total, rsp.fault_total, rsp.requests_seen};
                if (due_lookups.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %p",
                             $time, got_lookup);
                    mismatches++;
                end
                else
                begin
                    want_lookup = due_lookups.pop_front();
                    if (got_lookup !== want_lookup)
                    begin
                        $display({"%0t: lookup mismatch, expected hit=%0d slot=%0d ",
                                  "evicted=%0d page=%h hits=%0d faults=%0d reqs=%0d, ",
                                  "actual hit=%0d slot=%0d evicted=%0d page=%h ",
                                  "hits=%0d faults=%0d reqs=%0d"},
                                 $time, want_lookup.hit, want_lookup.slot,
                                 want_lookup.evicted, want_lookup.victim,
                                 want_lookup.hits, want_lookup.faults,
                                 want_lookup.requests, got_lookup.hit, got_lookup.slot,
                                 got_lookup.evicted, got_lookup.victim,
                                 got_lookup.hits, got_lookup.faults,
                                 got_lookup.requests);
                        mismatches++;
                    end
                end
            end

            if (req.valid && req.ready)
            begin
                lru_lookup(req.page_number, req.start_sequence, new_lookup);
                due_lookups.push_back(new_lookup);
            end
            pending_results = due_lookups.size();
        end
    end

endmodule

@@ tb/tb_lru_page_replacement.sv @@
`timescale 1ns / 1ps
module tb_lru_page_replacement;
    import lrupr_pkg::*;

    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 12;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 140;
    localparam int BURST_RUN     = 20;
    localparam int POOL_DEPTH    = 12;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_wr_en;
    logic [CFG_BITS-1:0] cfg_wr_data;
    int                  mismatches;
    int                  pending_results;
    int                  stall_cycles;
    bit                  calm;

    lrupr_in_if  req_ch ();
    lrupr_out_if rsp_ch ();

    lru_page_replacement u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_ch),
        .rsp         (rsp_ch)
    );

    lrupr_lookup_checker u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .req             (req_ch),
        .rsp             (rsp_ch),
        .mismatches      (mismatches),
        .pending_results (pending_results)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int pick_gap();
        return calm ? 0 : $urandom_range(0, 18);
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    // with valid still high, so a back-to-back item keeps it high.
    task automatic send_ref(input logic [PAGE_BITS_DEF-1:0] pg, input logic st);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid          <= 1'b1;
        req_ch.page_number    <= pg;
        req_ch.start_sequence <= st;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain_lookups();
        req_ch.valid <= 1'b0;
        while (pending_results != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_frames(input logic [CFG_BITS-1:0] value);
        drain_lookups();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    initial
    begin : result_sink
        int gap;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = pick_gap();
            if (gap > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
            while (!rsp_ch.valid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    initial
    begin : watchdog
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || cfg_wr_en)
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("status: fail");
        $finish;
    end

    initial
    begin : stimulus
        logic [PAGE_BITS_DEF-1:0] pool [POOL_DEPTH];
        logic [CFG_BITS-1:0]      phase_cfg [RANDOM_PHASES];
        logic [PAGE_BITS_DEF-1:0] pg;
        int                       pool_n;
        int                       p;
        int                       k;
        int                       n;

        rst_n                 = 1'b0;
        cfg_wr_en             = 1'b0;
        cfg_wr_data           = '0;
        req_ch.valid          = 1'b0;
        req_ch.page_number    = '0;
        req_ch.start_sequence = 1'b0;
        calm                  = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset width of three frames: fill, hit, then evict the oldest page.
        send_ref(16'h0000, 1'b1);
        send_ref(16'hFFFF, 1'b0);
        send_ref(16'h0000, 1'b0);
        send_ref(16'h1234, 1'b0);
        send_ref(16'h5555, 1'b0);
        send_ref(16'hFFFF, 1'b0);
        send_ref(16'hAAAA, 1'b0);
        send_ref(16'hFFFF, 1'b1);

        // A frame count of zero behaves as a single frame.
        write_frames(4'd0);
        send_ref(16'h0007, 1'b0);
        send_ref(16'h0007, 1'b0);

        // All eight frames: fill the empty ones, then one replacement.
        write_frames(4'd8);
        for (k = 1; k <= 8; k++)
            send_ref(16'h8000 | k[15:0], 1'b0);

        // Counts above the frame total are clamped.
        write_frames(4'd15);
        send_ref(16'h8001, 1'b0);

        // Shrinking the count mid-sequence can leave a page in two frames;
        // the lower frame must win the hit once the count grows again.
        write_frames(4'd2);
        send_ref(16'h0010, 1'b1);
        send_ref(16'h0020, 1'b0);
        write_frames(4'd1);
        send_ref(16'h0020, 1'b0);
        write_frames(4'd2);
        send_ref(16'h0020, 1'b0);

        // Back-to-back run on one frame: all faults, then a fault and hits.
        write_frames(4'd1);
        calm = 1'b1;
        send_ref(16'h0001, 1'b1);
        for (n = 0; n < BURST_RUN; n++)
            send_ref((n % 2 == 0) ? 16'h0002 : 16'h0001, 1'b0);
        for (n = 0; n < BURST_RUN; n++)
            send_ref(16'h0003, 1'b0);

        phase_cfg[0] = 4'd3;
        phase_cfg[1] = 4'd8;
        phase_cfg[2] = 4'd1;
        phase_cfg[3] = 4'd0;
        phase_cfg[4] = 4'd15;
        phase_cfg[5] = CFG_BITS'($urandom_range(0, 15));

        // Random phases draw mostly from a small working set so that hits and
        // replacements both happen, with some stray pages and restarts.
        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            write_frames(phase_cfg[p]);
            pool_n = $urandom_range(1, POOL_DEPTH);
            for (k = 0; k < POOL_DEPTH; k++)
                pool[k] = PAGE_BITS_DEF'($urandom_range(0, 65535));
            if ($urandom_range(0, 3) == 0)
                pool[0] = 16'hFFFF;
            if ($urandom_range(0, 3) == 0)
                pool[pool_n - 1] = 16'h0000;
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % 50 == 0)
                    calm = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 59) == 0)
                    drain_lookups();
                if ($urandom_range(0, 9) == 0)
                    pg = PAGE_BITS_DEF'($urandom_range(0, 65535));
                else
                    pg = pool[$urandom_range(0, pool_n - 1)];
                send_ref(pg, (p == 0 && n == 0) || ($urandom_range(0, 29) == 0));
            end
        end

        drain_lookups();
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ lru_page_replacement.f @@
+incdir+design
design/lrupr_pkg.sv
design/lrupr_in_if.sv
design/lrupr_out_if.sv
design/lrupr_stats.sv
design/lru_page_replacement.sv
tb/lrupr_lookup_checker.sv
tb/tb_lru_page_replacement.sv
